// ----- rtl/core/ggbs_pkg.sv -----
// ----------------------------------------------------------------------------
// ggbs_pkg
// Types and constants shared by the go-to-goal steering unit.
// ----------------------------------------------------------------------------
package ggbs_pkg;

  localparam int COORD_W   = 16;
  localparam int HEAD_W    = 15;
  localparam int TOL_W     = 14;
  localparam int RATE_W    = 17;
  localparam int ERR_W     = 16;
  localparam int DIST_W    = 17;
  localparam int DIFF_W    = 17;
  localparam int XY_W      = 28;
  localparam int Z_W       = 24;
  localparam int GUARD     = 8;
  localparam int MAG_W     = 27;
  localparam int GAIN_W    = 30;
  localparam int PROD_W    = MAG_W + GAIN_W;
  localparam int ATAN_LEN  = 24;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  localparam logic signed [Z_W-1:0] HALF_PI_Q20  = 24'sd1647099;
  localparam logic [TOL_W-1:0]      PI_Q12       = 14'd12868;
  localparam logic [GAIN_W-1:0]     INV_GAIN_Q30 = 30'd652032874;
  localparam logic [DIST_W-1:0]     DIST_MAX     = 17'd131071;

  localparam logic signed [Z_W-1:0] ATAN_Q20 [ATAN_LEN] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451, 24'sd32757,
    24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,   24'sd1024,  24'sd512,
    24'sd256,    24'sd128,    24'sd64,     24'sd32,     24'sd16,    24'sd8,
    24'sd4,      24'sd2,      24'sd1,      24'sd0,      24'sd0,     24'sd0
  };

  typedef enum logic [2:0] {
    REG_TARGET_X      = 3'd0,
    REG_TARGET_Y      = 3'd1,
    REG_HEADING_TOL   = 3'd2,
    REG_ARRIVAL_RAD   = 3'd3,
    REG_TURN_SPEED    = 3'd4,
    REG_FORWARD_SPEED = 3'd5
  } reg_idx_t;

  localparam logic [COORD_W-1:0] RST_TARGET_X      = 16'd0;
  localparam logic [COORD_W-1:0] RST_TARGET_Y      = 16'd0;
  localparam logic [TOL_W-1:0]   RST_HEADING_TOL   = 14'd205;
  localparam logic [COORD_W-1:0] RST_ARRIVAL_RAD   = 16'd410;
  localparam logic [COORD_W-1:0] RST_TURN_SPEED    = 16'd2048;
  localparam logic [COORD_W-1:0] RST_FORWARD_SPEED = 16'd4096;

  typedef struct packed {
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic [TOL_W-1:0]   heading_tolerance;
    logic [COORD_W-1:0] arrival_radius;
    logic [COORD_W-1:0] turn_speed;
    logic [COORD_W-1:0] forward_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic                     at_goal;
    logic signed [HEAD_W-1:0] heading;
  } cordic_t;

endpackage

// ----- rtl/core/ggbs_if.sv -----
// ----------------------------------------------------------------------------
// ggbs_if
// Valid/ready channels for pose samples and steering commands.
// ----------------------------------------------------------------------------
interface ggbs_pose_if;
  logic                                valid;
  logic                                ready;
  logic [ggbs_pkg::COORD_W-1:0]        pose_x;
  logic [ggbs_pkg::COORD_W-1:0]        pose_y;
  logic signed [ggbs_pkg::HEAD_W-1:0]  pose_heading;

  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface ggbs_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [ggbs_pkg::RATE_W-1:0]  angular_rate;
  logic [ggbs_pkg::COORD_W-1:0]        linear_rate;
  logic                                arrived;
  logic signed [ggbs_pkg::ERR_W-1:0]   heading_error;
  logic [ggbs_pkg::DIST_W-1:0]         goal_distance;

  modport source (output valid, angular_rate, linear_rate, arrived, heading_error,
                  goal_distance, input ready);
  modport sink   (input valid, angular_rate, linear_rate, arrived, heading_error,
                  goal_distance, output ready);
endinterface

// ----- rtl/core/ggbs_cfg.sv -----
// ----------------------------------------------------------------------------
// ggbs_cfg
// APB register file for goal, tolerances and speed commands.
// ----------------------------------------------------------------------------
module ggbs_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ggbs_pkg::APB_AW-1:0]    paddr,
  input  logic [ggbs_pkg::APB_DW-1:0]    pwdata,
  output logic [ggbs_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output ggbs_pkg::cfg_t                 cfg
);

  ggbs_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = ggbs_pkg::reg_idx_t'(paddr[ggbs_pkg::APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_x          <= ggbs_pkg::RST_TARGET_X;
      cfg.target_y          <= ggbs_pkg::RST_TARGET_Y;
      cfg.heading_tolerance <= ggbs_pkg::RST_HEADING_TOL;
      cfg.arrival_radius    <= ggbs_pkg::RST_ARRIVAL_RAD;
      cfg.turn_speed        <= ggbs_pkg::RST_TURN_SPEED;
      cfg.forward_speed     <= ggbs_pkg::RST_FORWARD_SPEED;
    end else if (wr) begin
      unique case (idx)
        ggbs_pkg::REG_TARGET_X:      cfg.target_x          <= pwdata[15:0];
        ggbs_pkg::REG_TARGET_Y:      cfg.target_y          <= pwdata[15:0];
        ggbs_pkg::REG_HEADING_TOL:   cfg.heading_tolerance <= pwdata[13:0];
        ggbs_pkg::REG_ARRIVAL_RAD:   cfg.arrival_radius    <= pwdata[15:0];
        ggbs_pkg::REG_TURN_SPEED:    cfg.turn_speed        <= pwdata[15:0];
        ggbs_pkg::REG_FORWARD_SPEED: cfg.forward_speed     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ggbs_pkg::REG_TARGET_X:      prdata = {16'd0, cfg.target_x};
      ggbs_pkg::REG_TARGET_Y:      prdata = {16'd0, cfg.target_y};
      ggbs_pkg::REG_HEADING_TOL:   prdata = {18'd0, cfg.heading_tolerance};
      ggbs_pkg::REG_ARRIVAL_RAD:   prdata = {16'd0, cfg.arrival_radius};
      ggbs_pkg::REG_TURN_SPEED:    prdata = {16'd0, cfg.turn_speed};
      ggbs_pkg::REG_FORWARD_SPEED: prdata = {16'd0, cfg.forward_speed};
      default:                     prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/ggbs_front.sv -----
// ----------------------------------------------------------------------------
// ggbs_front
// Offset to goal, guard scaling and quadrant pre-rotation for the CORDIC.
// ----------------------------------------------------------------------------
module ggbs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  ggbs_pkg::cfg_t       cfg,
  ggbs_pose_if.sink            pose,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ggbs_pkg::cordic_t    out_data
);

  logic signed [ggbs_pkg::DIFF_W-1:0] dx;
  logic signed [ggbs_pkg::DIFF_W-1:0] dy;
  logic signed [ggbs_pkg::XY_W-1:0]   xs;
  logic signed [ggbs_pkg::XY_W-1:0]   ys;
  ggbs_pkg::cordic_t                  data_next;
  logic                               en;

  assign en         = !out_valid || out_ready;
  assign pose.ready = en;

  assign dx = $signed({1'b0, cfg.target_x}) - $signed({1'b0, pose.pose_x});
  assign dy = $signed({1'b0, cfg.target_y}) - $signed({1'b0, pose.pose_y});
  assign xs = ggbs_pkg::XY_W'(dx) <<< ggbs_pkg::GUARD;
  assign ys = ggbs_pkg::XY_W'(dy) <<< ggbs_pkg::GUARD;

  always_comb begin
    data_next.heading = pose.pose_heading;
    data_next.at_goal = (dx == '0) && (dy == '0);
    if (xs < 0) begin
      if (ys >= 0) begin
        data_next.x = ys;
        data_next.y = -xs;
        data_next.z = ggbs_pkg::HALF_PI_Q20;
      end else begin
        data_next.x = -ys;
        data_next.y = xs;
        data_next.z = -ggbs_pkg::HALF_PI_Q20;
      end
    end else begin
      data_next.x = xs;
      data_next.y = ys;
      data_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pose.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && pose.valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/ggbs_cell.sv -----
// ----------------------------------------------------------------------------
// ggbs_cell
// One CORDIC vectoring micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module ggbs_cell #(
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ggbs_pkg::cordic_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ggbs_pkg::cordic_t    out_data
);

  localparam logic signed [ggbs_pkg::Z_W-1:0] ANGLE = ggbs_pkg::ATAN_Q20[SHIFT];

  logic signed [ggbs_pkg::XY_W-1:0] xs;
  logic signed [ggbs_pkg::XY_W-1:0] ys;
  ggbs_pkg::cordic_t                data_next;

  assign in_ready = !out_valid || out_ready;
  assign xs = in_data.x >>> SHIFT;
  assign ys = in_data.y >>> SHIFT;

  always_comb begin
    data_next.heading = in_data.heading;
    data_next.at_goal = in_data.at_goal;
    if (in_data.y >= 0) begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ANGLE;
    end else begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/ggbs_back.sv -----
// ----------------------------------------------------------------------------
// ggbs_back
// Bearing rounding, gain correction and steering decision; output register.
// ----------------------------------------------------------------------------
module ggbs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ggbs_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ggbs_pkg::cordic_t    in_data,
  ggbs_cmd_if.source           cmd
);

  logic                                 v1;
  logic                                 en1;
  logic                                 en2;
  logic [ggbs_pkg::Z_W:0]               zabs;
  logic [ggbs_pkg::Z_W:0]               zrnd;
  logic [ggbs_pkg::TOL_W-1:0]           bmag;
  logic signed [ggbs_pkg::ERR_W-1:0]    bearing;
  logic [ggbs_pkg::MAG_W-1:0]           xc;
  logic signed [ggbs_pkg::DIFF_W-1:0]   err_wide;
  logic [ggbs_pkg::PROD_W-1:0]          prod;
  logic signed [ggbs_pkg::ERR_W-1:0]    err1;
  logic [ggbs_pkg::PROD_W:0]            rsum;
  logic [ggbs_pkg::PROD_W-38:0]         mag;
  logic [ggbs_pkg::DIST_W-1:0]          goal_dist;
  logic signed [ggbs_pkg::DIFF_W-1:0]   err_s;
  logic signed [ggbs_pkg::DIFF_W-1:0]   tol_s;

  assign en2      = !cmd.valid || cmd.ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    zabs = in_data.z[ggbs_pkg::Z_W-1] ? ($unsigned(-{in_data.z[ggbs_pkg::Z_W-1], in_data.z}))
                                     : {1'b0, in_data.z};
    zrnd = (zabs + (ggbs_pkg::Z_W+1)'(128)) >> 8;
    bmag = (zrnd > (ggbs_pkg::Z_W+1)'(ggbs_pkg::PI_Q12)) ? ggbs_pkg::PI_Q12
                                                          : zrnd[ggbs_pkg::TOL_W-1:0];
    if (in_data.at_goal) begin
      bearing = '0;
    end else if (in_data.z[ggbs_pkg::Z_W-1]) begin
      bearing = -$signed({2'b00, bmag});
    end else begin
      bearing = $signed({2'b00, bmag});
    end
    err_wide = ggbs_pkg::DIFF_W'(bearing) - ggbs_pkg::DIFF_W'(in_data.heading);
    if (in_data.at_goal || in_data.x < 0) begin
      xc = '0;
    end else begin
      xc = in_data.x[ggbs_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      prod <= ggbs_pkg::PROD_W'(xc) * ggbs_pkg::PROD_W'(ggbs_pkg::INV_GAIN_Q30);
      err1 <= err_wide[ggbs_pkg::ERR_W-1:0];
    end
  end

  always_comb begin
    rsum      = {1'b0, prod} + ((ggbs_pkg::PROD_W+1)'(1) << 37);
    mag       = rsum[ggbs_pkg::PROD_W:38];
    goal_dist = (mag > (ggbs_pkg::PROD_W-37)'(ggbs_pkg::DIST_MAX)) ? ggbs_pkg::DIST_MAX
                                                                  : mag[ggbs_pkg::DIST_W-1:0];
    err_s     = ggbs_pkg::DIFF_W'(err1);
    tol_s     = $signed({3'b000, cfg.heading_tolerance});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (en2) begin
      cmd.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      cmd.heading_error <= err1;
      cmd.goal_distance <= goal_dist;
      priority if (err_s < -tol_s) begin
        cmd.angular_rate <= -$signed({1'b0, cfg.turn_speed});
        cmd.linear_rate  <= '0;
        cmd.arrived      <= 1'b0;
      end else if (err_s > tol_s) begin
        cmd.angular_rate <= $signed({1'b0, cfg.turn_speed});
        cmd.linear_rate  <= '0;
        cmd.arrived      <= 1'b0;
      end else if (goal_dist > ggbs_pkg::DIST_W'(cfg.arrival_radius)) begin
        cmd.angular_rate <= '0;
        cmd.linear_rate  <= cfg.forward_speed;
        cmd.arrived      <= 1'b0;
      end else begin
        cmd.angular_rate <= '0;
        cmd.linear_rate  <= '0;
        cmd.arrived      <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/go_to_goal_bang_bang_steering_unit.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_bang_bang_steering_unit
// Turn-then-drive steering toward a goal held in APB registers.
//
// Pose items (x, y, heading) arrive on the pose channel; one command item
// (angular rate, linear rate, arrival flag, heading error, distance) leaves
// on the cmd channel for each pose item, in order. The goal offset passes
// an input stage, a row of CORDIC_STAGES vectoring cells (one rotation per
// cell) and two output stages (rounding and gain multiply, then decision).
// One item is taken every cycle while the cmd receiver is not stalling.
// Each stage holds its item while the next one is full, so a stalled
// receiver only stops the stages behind the full ones and bubbles close up.
// Reset empties the pipeline and loads the default goal, tolerances and
// speeds. Write registers only while no item is in flight.
// ----------------------------------------------------------------------------
module go_to_goal_bang_bang_steering_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  ggbs_pose_if.sink                    pose,
  ggbs_cmd_if.source                   cmd,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ggbs_pkg::APB_AW-1:0]  paddr,
  input  logic [ggbs_pkg::APB_DW-1:0]  pwdata,
  output logic [ggbs_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  ggbs_pkg::cfg_t    cfg;
  ggbs_pkg::cordic_t stage_data  [CORDIC_STAGES+1];
  logic              stage_valid [CORDIC_STAGES+1];
  logic              stage_ready [CORDIC_STAGES+1];

  ggbs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ggbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pose      (pose),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_data  (stage_data[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ggbs_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  ggbs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (stage_valid[CORDIC_STAGES]),
    .in_ready (stage_ready[CORDIC_STAGES]),
    .in_data  (stage_data[CORDIC_STAGES]),
    .cmd      (cmd)
  );

endmodule

// ----- verif/tb_go_to_goal_bang_bang_steering_unit.sv -----
// ----------------------------------------------------------------------------
// tb_go_to_goal_bang_bang_steering_unit
// Self-checking bench for the go-to-goal steering unit.
//
// Pose items go in on the pose channel while goal and speed registers are
// loaded over APB between phases with the pipeline empty. A local CORDIC
// vectoring model predicts bearing, distance and the turn/drive/arrive
// decision for each accepted item, and every command item is compared
// field by field with the oldest prediction. Directed items cover the
// coordinate and heading extremes, goal at pose, bearing clamp near +/-pi
// and the tolerance edges; random phases then mix poses near the goal,
// headings close to the bearing and raw noise, under bursty sending and a
// stalling receiver.
// ----------------------------------------------------------------------------
module tb_go_to_goal_bang_bang_steering_unit;

  localparam int STAGES       = 16;
  localparam int LATENCY      = STAGES + 3;
  localparam int RANDOM_ITEMS = 750;
  localparam int RUN_LIMIT    = 400000;

  typedef struct packed {
    logic signed [ggbs_pkg::RATE_W-1:0] angular_rate;
    logic [ggbs_pkg::COORD_W-1:0]       linear_rate;
    logic                               arrived;
    logic signed [ggbs_pkg::ERR_W-1:0]  heading_error;
    logic [ggbs_pkg::DIST_W-1:0]        goal_distance;
  } steer_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ggbs_pkg::APB_AW-1:0] paddr;
  logic [ggbs_pkg::APB_DW-1:0] pwdata;
  logic [ggbs_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  ggbs_pose_if pose_ch ();
  ggbs_cmd_if  cmd_ch ();

  go_to_goal_bang_bang_steering_unit #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pose   (pose_ch),
    .cmd    (cmd_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  ggbs_pkg::cfg_t goal_cfg;
  steer_cmd_t     cmd_expected [$];
  steer_cmd_t     cmd_want;
  int             mismatches   = 0;
  int             result_count = 0;
  int             cycle_count  = 0;
  int             burst_left   = 0;
  int             stall_mode   = 0;
  int             stall_left   = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic steer_cmd_t predict_steer(logic [ggbs_pkg::COORD_W-1:0] px,
                                               logic [ggbs_pkg::COORD_W-1:0] py,
                                               logic signed [ggbs_pkg::HEAD_W-1:0] hd,
                                               ggbs_pkg::cfg_t c);
    longint dx, dy, vx, vy, vz, t, xs, ys, rot, bear, goal_dist, err, tol;
    steer_cmd_t r;
    dx = longint'(c.target_x) - longint'(px);
    dy = longint'(c.target_y) - longint'(py);
    bear = 0;
    goal_dist = 0;
    if (dx != 0 || dy != 0) begin
      vx = dx <<< ggbs_pkg::GUARD;
      vy = dy <<< ggbs_pkg::GUARD;
      vz = 0;
      if (vx < 0) begin
        t = vx;
        if (vy >= 0) begin
          vx = vy;
          vy = -t;
          vz = longint'(ggbs_pkg::HALF_PI_Q20);
        end else begin
          vx = -vy;
          vy = t;
          vz = -longint'(ggbs_pkg::HALF_PI_Q20);
        end
      end
      for (int i = 0; i < STAGES && i < 63; i++) begin
        rot = (i < ggbs_pkg::ATAN_LEN) ? longint'(ggbs_pkg::ATAN_Q20[i]) : 64'sd0;
        xs = vx >>> i;
        ys = vy >>> i;
        if (vy >= 0) begin
          vx = vx + ys;
          vy = vy - xs;
          vz = vz + rot;
        end else begin
          vx = vx - ys;
          vy = vy + xs;
          vz = vz - rot;
        end
      end
      if (vz >= 0) bear = (vz + 128) >>> 8;
      else bear = -((-vz + 128) >>> 8);
      if (bear > longint'(ggbs_pkg::PI_Q12)) bear = longint'(ggbs_pkg::PI_Q12);
      if (bear < -longint'(ggbs_pkg::PI_Q12)) bear = -longint'(ggbs_pkg::PI_Q12);
      if (vx < 0) vx = 0;
      goal_dist = (vx * longint'(ggbs_pkg::INV_GAIN_Q30) + (64'sd1 <<< (29 + ggbs_pkg::GUARD)))
                  >>> (30 + ggbs_pkg::GUARD);
      if (goal_dist > longint'(ggbs_pkg::DIST_MAX)) goal_dist = longint'(ggbs_pkg::DIST_MAX);
    end
    err = bear - longint'(hd);
    tol = longint'(c.heading_tolerance);
    r = '0;
    if (err < -tol) r.angular_rate = ggbs_pkg::RATE_W'(-longint'(c.turn_speed));
    else if (err > tol) r.angular_rate = ggbs_pkg::RATE_W'(longint'(c.turn_speed));
    else if (goal_dist > longint'(c.arrival_radius)) r.linear_rate = c.forward_speed;
    else r.arrived = 1'b1;
    r.heading_error = ggbs_pkg::ERR_W'(err);
    r.goal_distance = ggbs_pkg::DIST_W'(goal_dist);
    return r;
  endfunction

  // heading that leaves an error of exactly err_wanted, held to the 15-bit range
  function automatic logic signed [ggbs_pkg::HEAD_W-1:0] aligned_heading(
      logic [ggbs_pkg::COORD_W-1:0] px, logic [ggbs_pkg::COORD_W-1:0] py, int err_wanted);
    steer_cmd_t probe;
    longint h;
    probe = predict_steer(px, py, '0, goal_cfg);
    h = longint'(probe.heading_error) - err_wanted;
    if (h > 16383) h = 16383;
    if (h < -16384) h = -16384;
    return ggbs_pkg::HEAD_W'(h);
  endfunction

  function automatic logic [ggbs_pkg::COORD_W-1:0] near_coord(
      logic [ggbs_pkg::COORD_W-1:0] c, int spread);
    longint v;
    v = longint'(c) + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return ggbs_pkg::COORD_W'(v);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("ERROR: command item %0d: %s got %0h expected %0h", result_count, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
      if (cmd_expected.size() == 0) begin
        report_mismatch("unexpected item", '0, '0);
      end else begin
        cmd_want = cmd_expected.pop_front();
        check_field("angular_rate", 32'(cmd_ch.angular_rate), 32'(cmd_want.angular_rate));
        check_field("linear_rate", 32'(cmd_ch.linear_rate), 32'(cmd_want.linear_rate));
        check_field("arrived", 32'(cmd_ch.arrived), 32'(cmd_want.arrived));
        check_field("heading_error", 32'(cmd_ch.heading_error), 32'(cmd_want.heading_error));
        check_field("goal_distance", 32'(cmd_ch.goal_distance), 32'(cmd_want.goal_distance));
      end
      result_count++;
    end
  end

  initial begin
    cmd_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       cmd_ch.ready <= 1'b1;
        1:       cmd_ch.ready <= 1'($urandom_range(0, 1));
        2:       cmd_ch.ready <= ($urandom_range(0, 4) == 0);
        default: cmd_ch.ready <= ((cycle_count % 16) < 6);
      endcase
    end
  end

  task automatic send_pose(logic [ggbs_pkg::COORD_W-1:0] px, logic [ggbs_pkg::COORD_W-1:0] py,
                           logic signed [ggbs_pkg::HEAD_W-1:0] hd);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        pose_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pose_ch.valid        <= 1'b1;
    pose_ch.pose_x       <= px;
    pose_ch.pose_y       <= py;
    pose_ch.pose_heading <= hd;
    do @(posedge clk); while (pose_ch.ready !== 1'b1);
    cmd_expected.push_back(predict_steer(px, py, hd, goal_cfg));
  endtask

  task automatic drain_pipeline();
    pose_ch.valid <= 1'b0;
    burst_left = 0;
    while (cmd_expected.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic apb_write(ggbs_pkg::reg_idx_t idx, logic [31:0] value, bit junk);
    logic [31:0] width_mask;
    logic [31:0] data;
    width_mask = (idx == ggbs_pkg::REG_HEADING_TOL) ? 32'h3FFF : 32'hFFFF;
    data = junk ? $urandom : 32'd0;
    data = (data & ~width_mask) | (value & width_mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      ggbs_pkg::REG_TARGET_X:
        goal_cfg.target_x = data[ggbs_pkg::COORD_W-1:0];
      ggbs_pkg::REG_TARGET_Y:
        goal_cfg.target_y = data[ggbs_pkg::COORD_W-1:0];
      ggbs_pkg::REG_HEADING_TOL:
        goal_cfg.heading_tolerance = data[ggbs_pkg::TOL_W-1:0];
      ggbs_pkg::REG_ARRIVAL_RAD:
        goal_cfg.arrival_radius = data[ggbs_pkg::COORD_W-1:0];
      ggbs_pkg::REG_TURN_SPEED:
        goal_cfg.turn_speed = data[ggbs_pkg::COORD_W-1:0];
      ggbs_pkg::REG_FORWARD_SPEED:
        goal_cfg.forward_speed = data[ggbs_pkg::COORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_goal_cfg(logic [15:0] tx, logic [15:0] ty, logic [13:0] tol,
                               logic [15:0] rad, logic [15:0] turn, logic [15:0] fwd,
                               bit junk);
    drain_pipeline();
    apb_write(ggbs_pkg::REG_TARGET_X, 32'(tx), junk);
    apb_write(ggbs_pkg::REG_TARGET_Y, 32'(ty), junk);
    apb_write(ggbs_pkg::REG_HEADING_TOL, 32'(tol), junk);
    apb_write(ggbs_pkg::REG_ARRIVAL_RAD, 32'(rad), junk);
    apb_write(ggbs_pkg::REG_TURN_SPEED, 32'(turn), junk);
    apb_write(ggbs_pkg::REG_FORWARD_SPEED, 32'(fwd), junk);
  endtask

  task automatic send_random_pose();
    logic [ggbs_pkg::COORD_W-1:0] px, py;
    longint h;
    int kind, spread, w;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      px = ggbs_pkg::COORD_W'($urandom);
      py = ggbs_pkg::COORD_W'($urandom);
    end else begin
      spread = (kind < 8) ? 1024 : 64;
      px = near_coord(goal_cfg.target_x, spread);
      py = near_coord(goal_cfg.target_y, spread);
    end
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      w = int'(goal_cfg.heading_tolerance) + 8;
      send_pose(px, py, aligned_heading(px, py, int'($urandom_range(0, 2 * w)) - w));
    end else begin
      if (kind < 8) h = longint'($urandom_range(0, 25736)) - 12868;
      else h = longint'($urandom);
      send_pose(px, py, ggbs_pkg::HEAD_W'(h));
    end
  endtask

  task automatic test_reset_defaults();
    send_pose(16'd0, 16'd0, 15'sd0);
    send_pose(16'd4096, 16'd0, 15'sd0);
    send_pose(16'd0, 16'd4096, 15'sd0);
    send_pose(16'd0, 16'd0, -15'sd16384);
    send_pose(16'd0, 16'd0, 15'sd16383);
  endtask

  task automatic test_directed_geometry();
    load_goal_cfg(16'd32768, 16'd32768, 14'd205, 16'd410, 16'd2048, 16'd4096, 1'b0);
    send_pose(16'd0, 16'd0, aligned_heading(16'd0, 16'd0, 0));
    send_pose(16'd65535, 16'd65535, aligned_heading(16'd65535, 16'd65535, 0));
    send_pose(16'd0, 16'd65535, aligned_heading(16'd0, 16'd65535, 0));
    send_pose(16'd65535, 16'd0, aligned_heading(16'd65535, 16'd0, 0));
    send_pose(16'd32768, 16'd32768, 15'sd12868);
    send_pose(16'd32768, 16'd32768, -15'sd12868);
    send_pose(16'd32868, 16'd32768, aligned_heading(16'd32868, 16'd32768, 0));
    send_pose(16'd65535, 16'd32768, 15'sd0);
    send_pose(16'd65535, 16'd32769, 15'sd0);
    send_pose(16'd32768, 16'd32468, aligned_heading(16'd32768, 16'd32468, 0));
  endtask

  task automatic test_tolerance_edges();
    load_goal_cfg(16'd65535, 16'd0, 14'd0, 16'd0, 16'd65535, 16'd65535, 1'b0);
    send_pose(16'd0, 16'd65535, aligned_heading(16'd0, 16'd65535, 0));
    send_pose(16'd65535, 16'd0, 15'sd0);
    load_goal_cfg(16'd0, 16'd65535, 14'd1000, 16'd65535, 16'd1, 16'd2, 1'b0);
    send_pose(16'd0, 16'd0, aligned_heading(16'd0, 16'd0, 1000));
    send_pose(16'd0, 16'd0, aligned_heading(16'd0, 16'd0, 1001));
    send_pose(16'd0, 16'd0, aligned_heading(16'd0, 16'd0, -1000));
    send_pose(16'd0, 16'd0, aligned_heading(16'd0, 16'd0, -1001));
    load_goal_cfg(16'd0, 16'd0, 14'd12868, 16'd65535, 16'd300, 16'd400, 1'b0);
    send_pose(16'd65535, 16'd0, -15'sd12868);
    send_pose(16'd65535, 16'd1, 15'sd12868);
  endtask

  task automatic test_random_phases();
    logic [13:0] tol;
    logic [15:0] rad;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_goal_cfg(16'd0, 16'd0, 14'd0, 16'd0, 16'd65535, 16'd65535, 1'b0);
        1: load_goal_cfg(16'd65535, 16'd65535, 14'd12868, 16'd65535, 16'd0, 16'd0, 1'b1);
        default: begin
          tol = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(0, 400))
                                            : 14'($urandom_range(0, 12868));
          rad = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 2048)) : 16'($urandom);
          load_goal_cfg(16'($urandom), 16'($urandom), tol, rad, 16'($urandom), 16'($urandom),
                        1'b1);
        end
      endcase
      repeat (RANDOM_ITEMS / 6) send_random_pose();
    end
  endtask

  initial begin
    pose_ch.valid        <= 1'b0;
    pose_ch.pose_x       <= '0;
    pose_ch.pose_y       <= '0;
    pose_ch.pose_heading <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    goal_cfg.target_x          = ggbs_pkg::RST_TARGET_X;
    goal_cfg.target_y          = ggbs_pkg::RST_TARGET_Y;
    goal_cfg.heading_tolerance = ggbs_pkg::RST_HEADING_TOL;
    goal_cfg.arrival_radius    = ggbs_pkg::RST_ARRIVAL_RAD;
    goal_cfg.turn_speed        = ggbs_pkg::RST_TURN_SPEED;
    goal_cfg.forward_speed     = ggbs_pkg::RST_FORWARD_SPEED;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_geometry();
    test_tolerance_edges();
    test_random_phases();
    drain_pipeline();
    repeat (LATENCY) @(posedge clk);
    if (cmd_expected.size() != 0) begin
      report_mismatch("items left over", 32'(cmd_expected.size()), '0);
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ggbs_pkg.sv
rtl/core/ggbs_if.sv
rtl/core/ggbs_cfg.sv
rtl/core/ggbs_front.sv
rtl/core/ggbs_cell.sv
rtl/core/ggbs_back.sv
rtl/core/go_to_goal_bang_bang_steering_unit.sv
verif/tb_go_to_goal_bang_bang_steering_unit.sv
